[rtl/ofrl_pkg.sv]
// shared types and constants for the odometer flash ring logger
`default_nettype none

package ofrl_pkg;

   localparam int SLOT_COUNT_DEF = 1024;
   localparam int SLOT_BYTES_DEF = 4;

   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_PTR_W = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_CNT_W = $clog2(RSPQ_DEPTH + 1);

   localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

   localparam logic [15:0] DIST_PER_PULSE_RST = 16'd2;
   localparam logic [19:0] SAVE_INTERVAL_RST  = 20'd100;
   localparam logic [23:0] SECTOR_BASE_RST    = 24'd0;

   typedef enum logic [1:0] {
      OP_PULSE   = 2'd0,
      OP_TICK    = 2'd1,
      OP_RECOVER = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_ERASE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DIST_PER_PULSE = 2'd0,
      CSR_SAVE_INTERVAL  = 2'd1,
      CSR_SECTOR_BASE    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      cmd_type     flash_cmd;
      logic [23:0] flash_addr;
      logic [31:0] flash_data;
      logic [31:0] distance_m;
      logic        last;
   } rsp_item_type;

   // one or two results produced by a single request
   typedef struct packed {
      logic         first_vld;
      logic         second_vld;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

endpackage

`default_nettype wire

[rtl/ofrl_if.sv]
// channel interfaces: request, response and register write
`default_nettype none

interface ofrl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [9:0]  slot_index;
   logic [31:0] read_word;

   modport source (output valid, op, slot_index, read_word, input ready);
   modport sink (input valid, op, slot_index, read_word, output ready);
endinterface

interface ofrl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  flash_cmd;
   logic [23:0] flash_addr;
   logic [31:0] flash_data;
   logic [31:0] distance_m;
   logic        last;

   modport source (output valid, flash_cmd, flash_addr, flash_data, distance_m, last,
                   input ready);
   modport sink (input valid, flash_cmd, flash_addr, flash_data, distance_m, last,
                 output ready);
endinterface

interface ofrl_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [23:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/ofrl_core.sv]
// request register, odometer state and flash command generation
`default_nettype none

module ofrl_core #(
   parameter int SLOT_COUNT = ofrl_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = ofrl_pkg::SLOT_BYTES_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   ofrl_req_if.sink            req_ch,
   ofrl_csr_if.sink            csr_ch,
   input  wire                 room,
   output ofrl_pkg::push_type  push
);
   import ofrl_pkg::*;

   localparam int SLOT_W = $clog2(SLOT_COUNT);

   // configuration
   logic [15:0] dpp_ff;
   logic [19:0] interval_ff;
   logic [23:0] base_ff;

   // request register
   logic        in_vld_ff, in_vld_in;
   op_type      in_op_ff;
   logic [9:0]  in_idx_ff;
   logic [31:0] in_word_ff;

   // odometer state
   logic [31:0]       dist_ff, dist_in;
   logic [31:0]       saved_ff, saved_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       max_ff, max_in;

   logic              req_acc;
   logic              adv;
   logic [31:0]       diff;
   logic              due;
   logic [SLOT_W:0]   nxt;
   logic              wrap;
   logic [SLOT_W-1:0] wr_slot;
   logic [31:0]       slot_off;
   logic [23:0]       wr_addr;
   logic [31:0]       idx_ext;
   logic              in_range;
   logic [31:0]       scan_base;
   logic              take;
   logic [31:0]       take_max;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dpp_ff      <= DIST_PER_PULSE_RST;
         interval_ff <= SAVE_INTERVAL_RST;
         base_ff     <= SECTOR_BASE_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_DIST_PER_PULSE: dpp_ff      <= csr_ch.data[15:0];
            CSR_SAVE_INTERVAL:  interval_ff <= csr_ch.data[19:0];
            CSR_SECTOR_BASE:    base_ff     <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign adv          = in_vld_ff && room;
   assign req_ch.ready = !in_vld_ff || room;
   assign req_acc      = req_ch.valid && req_ch.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_acc) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_op_ff   <= op_type'(req_ch.op);
         in_idx_ff  <= req_ch.slot_index;
         in_word_ff <= req_ch.read_word;
      end
   end

   // save decision and slot address
   assign diff     = dist_ff - saved_ff;
   assign due      = diff >= 32'(interval_ff);
   assign nxt      = (SLOT_W + 1)'(slot_ff) + (SLOT_W + 1)'(1);
   assign wrap     = nxt >= (SLOT_W + 1)'(SLOT_COUNT);
   assign wr_slot  = wrap ? '0 : nxt[SLOT_W-1:0];
   assign slot_off = 32'(wr_slot) * 32'(SLOT_BYTES);
   assign wr_addr  = base_ff + slot_off[23:0];

   // recovery scan
   assign idx_ext   = 32'(in_idx_ff);
   assign in_range  = idx_ext < 32'(SLOT_COUNT);
   assign scan_base = (in_idx_ff == 10'd0) ? 32'd0 : max_ff;
   assign take      = (in_word_ff != ERASED_WORD) && (in_word_ff >= scan_base);
   assign take_max  = take ? in_word_ff : scan_base;

   always_comb begin
      dist_in  = dist_ff;
      saved_in = saved_ff;
      slot_in  = slot_ff;
      max_in   = max_ff;

      push.first_vld             = adv;
      push.second_vld            = 1'b0;
      push.first.flash_cmd       = CMD_NONE;
      push.first.flash_addr      = '0;
      push.first.flash_data      = '0;
      push.first.distance_m      = dist_ff;
      push.first.last            = 1'b1;
      push.second.flash_cmd      = CMD_WRITE;
      push.second.flash_addr     = wr_addr;
      push.second.flash_data     = dist_ff;
      push.second.distance_m     = dist_ff;
      push.second.last           = 1'b1;

      unique case (in_op_ff)
         OP_PULSE: begin
            dist_in               = dist_ff + 32'(dpp_ff);
            push.first.distance_m = dist_ff + 32'(dpp_ff);
         end
         OP_TICK: begin
            if (due) begin
               saved_in = dist_ff;
               slot_in  = wr_slot;
               if (wrap) begin
                  // erase the sector before going back to slot 0
                  push.second_vld       = adv;
                  push.first.flash_cmd  = CMD_ERASE;
                  push.first.flash_addr = base_ff;
                  push.first.last       = 1'b0;
               end else begin
                  push.first.flash_cmd  = CMD_WRITE;
                  push.first.flash_addr = wr_addr;
                  push.first.flash_data = dist_ff;
               end
            end
         end
         OP_RECOVER: begin
            if (in_range) begin
               max_in   = take_max;
               dist_in  = take_max;
               saved_in = take_max;
               if (take) begin
                  slot_in = idx_ext[SLOT_W-1:0];
               end
               push.first.distance_m = take_max;
            end
         end
         OP_CLEAR: begin
            dist_in                = '0;
            saved_in               = '0;
            slot_in                = '0;
            max_in                 = '0;
            push.second_vld        = adv;
            push.first.flash_cmd   = CMD_ERASE;
            push.first.flash_addr  = base_ff;
            push.first.distance_m  = '0;
            push.first.last        = 1'b0;
            push.second.flash_addr = base_ff;
            push.second.flash_data = '0;
            push.second.distance_m = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff  <= '0;
         saved_ff <= '0;
         slot_ff  <= '0;
         max_ff   <= '0;
      end else if (adv) begin
         dist_ff  <= dist_in;
         saved_ff <= saved_in;
         slot_ff  <= slot_in;
         max_ff   <= max_in;
      end
   end

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < 32'(SLOT_COUNT))
      else $error("current slot beyond sector");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.second_vld |-> (!push.first.last && push.second.last &&
                           push.first.flash_cmd == CMD_ERASE))
      else $error("two-result transaction not erase then final write");

   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      (adv && in_op_ff == OP_CLEAR) |=> (dist_ff == 32'd0 && slot_ff == '0))
      else $error("clear did not zero the odometer state");

endmodule

`default_nettype wire

[rtl/ofrl_rsp_queue.sv]
// small response queue taking up to two results per cycle
`default_nettype none

module ofrl_rsp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  ofrl_pkg::push_type  push,
   output logic                room,
   ofrl_rsp_if.source          rsp_ch
);
   import ofrl_pkg::*;

   rsp_item_type          entry_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_CNT_W-1:0] count_ff, count_in;
   logic [RSPQ_PTR_W-1:0] wr_ptr_nx;
   logic                  pop;
   rsp_item_type          head;

   // room for a full two-result transaction regardless of the reader
   assign room      = count_ff <= RSPQ_CNT_W'(RSPQ_DEPTH - 2);
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign wr_ptr_nx = wr_ptr_ff + RSPQ_PTR_W'(1);
   assign head      = entry_ff[rd_ptr_ff];

   assign rsp_ch.valid      = count_ff != '0;
   assign rsp_ch.flash_cmd  = head.flash_cmd;
   assign rsp_ch.flash_addr = head.flash_addr;
   assign rsp_ch.flash_data = head.flash_data;
   assign rsp_ch.distance_m = head.distance_m;
   assign rsp_ch.last       = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.first_vld && push.second_vld) begin
         wr_ptr_in = wr_ptr_ff + RSPQ_PTR_W'(2);
         count_in  = count_ff + RSPQ_CNT_W'(2);
      end else if (push.first_vld) begin
         wr_ptr_in = wr_ptr_nx;
         count_in  = count_ff + RSPQ_CNT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + RSPQ_PTR_W'(1);
         count_in  = count_in - RSPQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_vld) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.first_vld && push.second_vld) begin
         entry_ff[wr_ptr_nx] <= push.second;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSPQ_CNT_W'(RSPQ_DEPTH))
      else $error("response queue overflow");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.second_vld |-> push.first_vld)
      else $error("second result pushed without first");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.first_vld |-> count_ff <= RSPQ_CNT_W'(RSPQ_DEPTH - 2))
      else $error("push into queue without room");

endmodule

`default_nettype wire

[rtl/odometer_flash_ring_logger.sv]
// top level of the odometer flash ring logger
// Usage:
//   req_ch carries one transaction per event: wheel pulse, service tick,
//   recovered slot word or clear log. Each is taken when valid and ready
//   are high on a rising clock edge.
//   rsp_ch returns one result per transaction, or two (erase then write)
//   for a clear or a save that wraps the slot ring; last marks the final one.
//   csr_ch writes distance per pulse, save interval and sector base; it is
//   always ready and should only be used while the block is idle.
// Path: a transaction's results pass through the request register, then
//   the response queue, before they are offered on rsp_ch.
// Throughput: one transaction per cycle for single-result events while the
//   response queue has room for two results; erase and write pairs leave
//   the response port one result at a time.
// Reset (synchronous) zeroes distance, saved distance, slot and scan maximum
//   and restores the register defaults.
// When the receiver stalls, the four-entry response queue fills; req_ch
//   ready drops while a transaction waits in the request register and fewer
//   than two queue entries are free.
`default_nettype none

module odometer_flash_ring_logger #(
   parameter int SLOT_COUNT = ofrl_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = ofrl_pkg::SLOT_BYTES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   ofrl_req_if.sink   req_ch,
   ofrl_rsp_if.source rsp_ch,
   ofrl_csr_if.sink   csr_ch
);
   import ofrl_pkg::*;

   push_type push;
   logic     room;

   ofrl_core #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .csr_ch (csr_ch),
      .room   (room),
      .push   (push)
   );

   ofrl_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

[bench/ofrl_flash_checker.sv]
// checker for the odometer logger: mirrors its state from the channels and compares flash commands
`timescale 1ns / 100ps

module ofrl_flash_checker (
   input  wire clock,
   input  wire reset,
   ofrl_req_if req_ch,
   ofrl_rsp_if rsp_ch,
   ofrl_csr_if csr_ch,
   output int  fail_count,
   output int  pending,
   output int  checked,
   output int  erases,
   output int  writes
);
   import ofrl_pkg::*;

   logic [15:0] dist_step;
   logic [19:0] save_gap;
   logic [23:0] sector_base;

   logic [31:0] odo;
   logic [31:0] odo_saved;
   logic [31:0] scan_max;
   int unsigned slot;

   rsp_item_type pending_flash_ops[$];

   function automatic logic [23:0] slot_addr(int unsigned s);
      logic [31:0] sum;
      sum = {8'd0, sector_base} + s * SLOT_BYTES_DEF;
      return sum[23:0];
   endfunction

   function automatic rsp_item_type flash_op(cmd_type cmd, logic [23:0] addr,
                                             logic [31:0] data);
      rsp_item_type r;
      r.flash_cmd  = cmd;
      r.flash_addr = addr;
      r.flash_data = data;
      r.distance_m = odo;
      r.last       = 1'b0;
      return r;
   endfunction

   // advances the mirrored logger state and queues the flash commands it issues
   function automatic void apply_logger_event(logic [1:0] op, logic [9:0] idx,
                                              logic [31:0] word);
      rsp_item_type ops [2];
      int n;
      int unsigned next;
      logic [31:0] moved;
      n = 0;
      case (op)
         OP_PULSE: begin
            odo = odo + {16'd0, dist_step};
            ops[n] = flash_op(CMD_NONE, 24'd0, 32'd0);
            n = n + 1;
         end
         OP_TICK: begin
            // distance travelled since the last save, modulo 2^32
            moved = odo - odo_saved;
            if (moved >= {12'd0, save_gap}) begin
               next = slot + 1;
               if (next >= SLOT_COUNT_DEF) begin
                  ops[n] = flash_op(CMD_ERASE, sector_base, 32'd0);
                  n = n + 1;
                  next = 0;
               end
               slot = next;
               odo_saved = odo;
               ops[n] = flash_op(CMD_WRITE, slot_addr(slot), odo);
               n = n + 1;
            end else begin
               ops[n] = flash_op(CMD_NONE, 24'd0, 32'd0);
               n = n + 1;
            end
         end
         OP_RECOVER: begin
            if (idx < SLOT_COUNT_DEF) begin
               if (idx == 10'd0) scan_max = 32'd0;
               // erased words are skipped, a tie goes to the later slot
               if (word != ERASED_WORD && word >= scan_max) begin
                  scan_max = word;
                  slot = idx;
               end
               odo = scan_max;
               odo_saved = scan_max;
            end
            ops[n] = flash_op(CMD_NONE, 24'd0, 32'd0);
            n = n + 1;
         end
         default: begin
            odo = 32'd0;
            odo_saved = 32'd0;
            slot = 0;
            scan_max = 32'd0;
            ops[n] = flash_op(CMD_ERASE, sector_base, 32'd0);
            n = n + 1;
            ops[n] = flash_op(CMD_WRITE, slot_addr(0), 32'd0);
            n = n + 1;
         end
      endcase
      ops[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++) pending_flash_ops.push_back(ops[k]);
   endfunction

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         dist_step   = DIST_PER_PULSE_RST;
         save_gap    = SAVE_INTERVAL_RST;
         sector_base = SECTOR_BASE_RST;
         odo         = 32'd0;
         odo_saved   = 32'd0;
         scan_max    = 32'd0;
         slot        = 0;
         pending_flash_ops.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.flash_cmd  = cmd_type'(rsp_ch.flash_cmd);
            got.flash_addr = rsp_ch.flash_addr;
            got.flash_data = rsp_ch.flash_data;
            got.distance_m = rsp_ch.distance_m;
            got.last       = rsp_ch.last;
            checked++;
            if (got.flash_cmd == CMD_ERASE) erases++;
            if (got.flash_cmd == CMD_WRITE) writes++;
            if (pending_flash_ops.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected transaction: cmd %0d addr %h data %h dist %h last %b",
                           got.flash_cmd, got.flash_addr, got.flash_data, got.distance_m,
                           got.last);
            end else begin
               want = pending_flash_ops.pop_front();
               if (got.flash_cmd !== want.flash_cmd || got.flash_addr !== want.flash_addr ||
                   got.flash_data !== want.flash_data ||
                   got.distance_m !== want.distance_m || got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("flash command mismatch: expected cmd %0d addr %h data %h ",
                              want.flash_cmd, want.flash_addr, want.flash_data,
                              "dist %h last %b, ", want.distance_m, want.last,
                              "got cmd %0d addr %h data %h dist %h last %b",
                              got.flash_cmd, got.flash_addr, got.flash_data,
                              got.distance_m, got.last);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            apply_logger_event(req_ch.op, req_ch.slot_index, req_ch.read_word);
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_DIST_PER_PULSE: dist_step   = csr_ch.data[15:0];
               CSR_SAVE_INTERVAL:  save_gap    = csr_ch.data[19:0];
               CSR_SECTOR_BASE:    sector_base = csr_ch.data;
               default: ;
            endcase
         end
      end
      pending = pending_flash_ops.size();
   end

endmodule

[bench/odometer_flash_ring_logger_test.sv]
// testbench top for the odometer flash ring logger: stimulus, register settings and verdict
`timescale 1ns / 100ps

module odometer_flash_ring_logger_test;
   import ofrl_pkg::*;

   localparam int RUN_LIMIT   = 400000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int cycle_count;
   int fail_count;
   int pending;
   int checked;
   int erases;
   int writes;
   int items_sent;
   int settings_used;
   bit steady_flow;

   ofrl_req_if req_ch ();
   ofrl_rsp_if rsp_ch ();
   ofrl_csr_if csr_ch ();

   odometer_flash_ring_logger u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ofrl_flash_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .erases     (erases),
      .writes     (writes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timed out after %0d cycles with %0d responses outstanding",
                  cycle_count, pending);
         $display("simulation failed");
         $finish;
      end
   end

   // response side: random stall before each transaction
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_event(op_type op, logic [9:0] idx, logic [31:0] word);
      int gap;
      if ($urandom_range(0, 63) == 0) steady_flow = ~steady_flow;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.op         = op;
      req_ch.slot_index = idx;
      req_ch.read_word  = word;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [23:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic configure(logic [15:0] step, logic [19:0] gap, logic [23:0] base);
      settle();
      write_reg(CSR_DIST_PER_PULSE, {8'd0, step});
      write_reg(CSR_SAVE_INTERVAL, {4'd0, gap});
      write_reg(CSR_SECTOR_BASE, base);
      settings_used++;
   endtask

   initial begin
      int sent;
      int len;
      int step_i;
      int r;
      logic [15:0] step;
      logic [19:0] gap;
      logic [23:0] base;
      logic [9:0]  idx;
      logic [31:0] word;
      logic [31:0] prev_word;

      req_ch.valid      = 1'b0;
      req_ch.op         = OP_PULSE;
      req_ch.slot_index = 10'd0;
      req_ch.read_word  = 32'd0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_DIST_PER_PULSE;
      csr_ch.data       = 24'd0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // register defaults: clear, idle tick, then a recovery scan with skip and tie
      send_event(OP_CLEAR, 10'h3FF, 32'hFFFF_FFFF);
      send_event(OP_PULSE, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);
      send_event(OP_RECOVER, 10'd0, 32'd100);
      send_event(OP_RECOVER, 10'd1, ERASED_WORD);
      send_event(OP_RECOVER, 10'd1023, 32'hFFFF_FFFE);
      send_event(OP_RECOVER, 10'd7, 32'hFFFF_FFFE);
      send_event(OP_RECOVER, 10'd9, 32'd5);
      send_event(OP_RECOVER, 10'd1023, 32'hFFFF_FFFE);
      send_event(OP_PULSE, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);

      // largest step, zero interval, top base address: ring wrap and address wrap
      configure(16'hFFFF, 20'd0, 24'hFF_FFFF);
      send_event(OP_TICK, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);
      send_event(OP_PULSE, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);
      send_event(OP_RECOVER, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);
      send_event(OP_CLEAR, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);

      // zero step, largest interval
      configure(16'd0, 20'hF_FFFF, 24'd0);
      send_event(OP_PULSE, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);
      send_event(OP_RECOVER, 10'd0, 32'hFFFF_FFFE);
      send_event(OP_PULSE, 10'd0, 32'd0);
      send_event(OP_TICK, 10'd0, 32'd0);

      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 5))
            0:       step_i = 0;
            1:       step_i = 65535;
            2:       step_i = 1;
            default: step_i = $urandom_range(1, 1000);
         endcase
         step = step_i[15:0];
         case ($urandom_range(0, 4))
            0:       gap = 20'd0;
            1:       gap = 20'hF_FFFF;
            default: gap = 20'($urandom_range(0, 4 * step_i + 10));
         endcase
         case ($urandom_range(0, 3))
            0:       base = 24'd0;
            1:       base = 24'hFF_FFFF;
            default: base = 24'($urandom());
         endcase
         configure(step, gap, base);

         sent = 0;
         prev_word = $urandom_range(0, 100000);
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               send_event(OP_PULSE, 10'($urandom()), $urandom());
               sent++;
            end else if (r < 70) begin
               send_event(OP_TICK, 10'($urandom()), $urandom());
               sent++;
            end else if (r < 96) begin
               // a recovery scan, now and then without the restart at slot 0
               len = $urandom_range(1, 6);
               if ($urandom_range(0, 3) == 0) prev_word = $urandom();
               for (int k = 0; k < len; k++) begin
                  if (k == 0 && $urandom_range(0, 4) != 0) idx = 10'd0;
                  else if ($urandom_range(0, 1) == 1) idx = 10'($urandom_range(1016, 1023));
                  else idx = 10'($urandom_range(0, 1023));
                  case ($urandom_range(0, 4))
                     0:       word = ERASED_WORD;
                     1:       word = $urandom();
                     2:       word = prev_word;
                     default: word = prev_word + $urandom_range(0, 500);
                  endcase
                  if (word != ERASED_WORD) prev_word = word;
                  send_event(OP_RECOVER, idx, word);
                  sent++;
               end
            end else begin
               send_event(OP_CLEAR, 10'($urandom()), $urandom());
               sent++;
            end
         end
      end

      settle();
      $display("%0d events sent under %0d register settings", items_sent, settings_used + 1);
      $display("%0d responses checked, %0d erases and %0d writes among them",
               checked, erases, writes);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[odometer_flash_ring_logger.f]
rtl/ofrl_pkg.sv
rtl/ofrl_if.sv
rtl/ofrl_core.sv
rtl/ofrl_rsp_queue.sv
rtl/odometer_flash_ring_logger.sv
bench/ofrl_flash_checker.sv
bench/odometer_flash_ring_logger_test.sv
